// ===== hw/rtl/i2cmw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_pkg
// Shared types and constants for the I2C master write sequencer.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

  localparam int unsigned AddrW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TimeW  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned BitIdxW = 4;
  localparam int unsigned ByteIdxW = 2;

  localparam logic [AddrW-1:0] TargetAddrRst = 7'd0;
  localparam logic [ByteW-1:0] FirstByteRst  = 8'd170;
  localparam logic [ByteW-1:0] SecondByteRst = 8'd48;
  localparam logic [TimeW-1:0] HalfTicksRst  = 12'd50;
  localparam logic [TimeW-1:0] SetupTicksRst = 12'd3000;

  // bits per byte before the ACK slot
  localparam logic [BitIdxW-1:0] BitsPerByte = 4'd8;
  // index of the last data byte
  localparam logic [ByteIdxW-1:0] LastByteIdx = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_ADDR = 3'd0,
    CFG_FIRST_BYTE  = 3'd1,
    CFG_SECOND_BYTE = 3'd2,
    CFG_HALF_PERIOD = 3'd3,
    CFG_SETUP_WAIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SETUP     = 4'd1,
    PH_START     = 4'd2,
    PH_BIT_LOW   = 4'd3,
    PH_BIT_HIGH  = 4'd4,
    PH_ACK_LOW   = 4'd5,
    PH_ACK_HIGH  = 4'd6,
    PH_STOP_LOW  = 4'd7,
    PH_STOP_HIGH = 4'd8
  } phase_e;

  typedef struct packed {
    logic [AddrW-1:0] target_addr;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
    logic [TimeW-1:0] half_period_ticks;
    logic [TimeW-1:0] setup_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic nack_seen;
  } result_t;

  // Byte sent in slot idx: address with W bit, then the two data bytes.
  function automatic logic [ByteW-1:0] byte_for(input cfg_t cfg,
                                                input logic [ByteIdxW-1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = {cfg.target_addr, 1'b0};
      2'd1:    b = cfg.first_byte;
      default: b = cfg.second_byte;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/i2cmw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmw_cfg_regs
// Write-only configuration registers; out-of-range indexes are dropped.
// ----------------------------------------------------------------------------
module i2cmw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cmw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cmw_pkg::CfgDataW-1:0] cfg_data_i,
  output i2cmw_pkg::cfg_t                cfg_o
);
  import i2cmw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_ADDR: cfg_d.target_addr       = cfg_data_i[AddrW-1:0];
        CFG_FIRST_BYTE:  cfg_d.first_byte        = cfg_data_i[ByteW-1:0];
        CFG_SECOND_BYTE: cfg_d.second_byte       = cfg_data_i[ByteW-1:0];
        CFG_HALF_PERIOD: cfg_d.half_period_ticks = cfg_data_i[TimeW-1:0];
        CFG_SETUP_WAIT:  cfg_d.setup_wait_ticks  = cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_addr       <= TargetAddrRst;
      cfg_q.first_byte        <= FirstByteRst;
      cfg_q.second_byte       <= SecondByteRst;
      cfg_q.half_period_ticks <= HalfTicksRst;
      cfg_q.setup_wait_ticks  <= SetupTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/i2c_master_write_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer_core
// Tick-driven I2C master: setup wait, START, address+W, two data bytes with
// ACK checks, STOP. A NACK restarts from the setup wait.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  --------+-------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o | cmd_i, sda_in_i (one request = 1 tick)
//  out     | out_valid_o/out_ready_i | scl/sda level, sda_drive, busy/done/nack
//  cfg     | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// Each request is handled at acceptance: the sequencer state and the result
// register update together, so one tick per clock is sustained while the
// results are taken. A result appears in the cycle after its request and
// sits in the output register until taken; a new request is still accepted
// in the cycle the result is taken. Reset puts the sequencer in idle with
// the register reset values loaded; the output register starts empty.
// ----------------------------------------------------------------------------
module i2c_master_write_sequencer_core #(
  parameter int unsigned TICK_COUNT_WIDTH = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tick requests
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic                           sda_in_i,
  // per-tick results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           scl_level_o,
  output logic                           sda_level_o,
  output logic                           sda_drive_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic                           nack_seen_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [i2cmw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cmw_pkg::CfgDataW-1:0] cfg_data_i
);
  import i2cmw_pkg::*;

  localparam int unsigned TcW  = TICK_COUNT_WIDTH;
  // compare width: wide enough for either operand plus the +1
  localparam int unsigned CmpW = ((TcW > TimeW) ? TcW : TimeW) + 1;

  cfg_t cfg;

  i2cmw_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer state
  phase_e               phase_q, phase_d;
  logic [TcW-1:0]       tick_q, tick_d;
  logic [BitIdxW-1:0]   bit_q, bit_d;
  logic [ByteIdxW-1:0]  byte_q, byte_d;
  logic [ByteW-1:0]     shift_q, shift_d;

  // output stage
  logic                 out_valid_q;
  result_t              res_q, res_d;

  logic                 accept;
  logic                 start;
  phase_e               ph;
  logic [TcW-1:0]       tc;
  logic [TimeW-1:0]     dur;
  logic [CmpW-1:0]      tc_next_w;
  logic                 last;
  logic [BitIdxW-1:0]   bit_inc;
  logic [ByteIdxW-1:0]  byte_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // a start request in idle enters the setup wait on this very tick
    start = (phase_q == PH_IDLE) && cmd_i;
    ph    = start ? PH_SETUP : phase_q;
    tc    = start ? '0 : tick_q;

    // zero duration acts as one; the all-ones counter value always ends a
    // phase, which caps durations at the counter range
    dur = (ph == PH_SETUP) ? cfg.setup_wait_ticks : cfg.half_period_ticks;
    if (dur == '0) begin
      dur = TimeW'(1);
    end
    tc_next_w = CmpW'(tc) + CmpW'(1);
    last      = (tc_next_w >= CmpW'(dur)) || (&tc);

    bit_inc  = bit_q + BitIdxW'(1);
    byte_inc = byte_q + ByteIdxW'(1);

    phase_d = ph;
    tick_d  = last ? '0 : tc + TcW'(1);
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;

    res_d.scl_level = 1'b1;
    res_d.sda_level = 1'b1;
    res_d.sda_drive = 1'b1;
    res_d.busy_res  = 1'b1;
    res_d.done_res  = 1'b0;
    res_d.nack_seen = 1'b0;

    case (ph)
      PH_IDLE: begin
        tick_d         = tick_q;
        res_d.busy_res = 1'b0;
      end
      PH_SETUP: begin
        if (last) begin
          phase_d = PH_START;
        end
      end
      PH_START: begin
        res_d.sda_level = 1'b0;
        if (last) begin
          byte_d  = '0;
          bit_d   = '0;
          shift_d = byte_for(cfg, '0);
          phase_d = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = shift_q[ByteW-1];
        if (last) begin
          phase_d = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        res_d.sda_level = shift_q[ByteW-1];
        if (last) begin
          shift_d = {shift_q[ByteW-2:0], 1'b0};
          bit_d   = bit_inc;
          phase_d = (bit_inc >= BitsPerByte) ? PH_ACK_LOW : PH_BIT_LOW;
        end
      end
      PH_ACK_LOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_drive = 1'b0;
        if (last) begin
          phase_d = PH_ACK_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        res_d.sda_drive = 1'b0;
        if (last) begin
          if (sda_in_i) begin
            // NACK: retry the whole transaction
            res_d.nack_seen = 1'b1;
            phase_d         = PH_SETUP;
          end else if (byte_q >= LastByteIdx) begin
            phase_d = PH_STOP_LOW;
          end else begin
            byte_d  = byte_inc;
            bit_d   = '0;
            shift_d = byte_for(cfg, byte_inc);
            phase_d = PH_BIT_LOW;
          end
        end
      end
      PH_STOP_LOW: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = 1'b0;
        if (last) begin
          phase_d = PH_STOP_HIGH;
        end
      end
      PH_STOP_HIGH: begin
        res_d.sda_level = 1'b0;
        if (last) begin
          res_d.done_res = 1'b1;
          phase_d        = PH_IDLE;
        end
      end
      default: begin
        // unused codes fall back to idle
        phase_d        = PH_IDLE;
        tick_d         = tick_q;
        res_d.busy_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = res_q.scl_level;
  assign sda_level_o = res_q.sda_level;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign nack_seen_o = res_q.nack_seen;

endmodule
